>>> rtl/kwm_pkg.sv
// Shared types and constants for the k-way merge of event lists.
// No dependencies; imported by every module under rtl/.
package kwm_pkg;

   // Default sizing, handed to the top level parameters
   localparam int KWM_NUM_LISTS     = 8;
   localparam int KWM_LIST_DEPTH    = 64;
   localparam int KWM_KEY_WIDTH     = 32;
   localparam int KWM_PAYLOAD_WIDTH = 32;

   // Stream and register port widths
   localparam int REQ_TDATA_W = 88;  // 85 field bits padded to bytes
   localparam int RSP_TDATA_W = 72;  // 67 field bits padded to bytes
   localparam int RSP_TUSER_W = 3;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_STALE     = 3'd2,
      ST_NOT_READY = 3'd3,
      ST_FINISHED  = 3'd4
   } status_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_EXPECTED_LISTS  = 1'd0,
      CSR_CURRENT_REQUEST = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [31:0] event_payload;
      logic [31:0] event_key;
      logic [2:0]  list_index;
      logic [15:0] request_id;
      logic [1:0]  command;
      logic        last_of_list;
   } item_type;

endpackage

>>> rtl/k_way_merge_event_lists_unit.sv
// Top level of the k-way merge: list bookkeeping, head cache, result register.
// Depends on kwm_pkg, kwm_store and kwm_min_sel.
//
// Usage:
//   req_* channel carries commands: push an event into one list, pop the
//   smallest head over all lists, or clear all lists. Each accepted beat
//   gives exactly one rsp_* beat carrying status and, for a pop, the event.
//   csr_* is a plain write port: index 0 expected list count, index 1 the
//   request id whose pushes are taken. Write it only while idle.
// Path: an accepted beat sits in the input register and is presented on
//   rsp_* from the result register, unless a head refetch or a stalled
//   result holds it back.
// Throughput: one beat per cycle while rsp_tready is high. A pop that leaves
//   more events in its list holds off the next beat while the list's next
//   head is read from the event store (registered read) into the head cache
//   before the next compare.
// Heads of all lists sit in flops; a compare tree picks the smallest, lowest
//   list index on ties. Pushing into an empty list loads the head directly.
// Reset (synchronous, active high) empties all lists, sets expected lists to
//   1 and current request to 0. Store contents are not cleared; only written
//   entries are ever read, so no clearing pass is needed.
// Stall: when rsp_tready is low the result holds in its register and the
//   input register still takes one more beat before req_tready drops.
module k_way_merge_event_lists_unit #(
   parameter int NUM_LISTS     = kwm_pkg::KWM_NUM_LISTS,
   parameter int LIST_DEPTH    = kwm_pkg::KWM_LIST_DEPTH,
   parameter int KEY_WIDTH     = kwm_pkg::KWM_KEY_WIDTH,
   parameter int PAYLOAD_WIDTH = kwm_pkg::KWM_PAYLOAD_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: command[1:0], request_id[17:2], list_index[20:18],
   //            event_key[52:21], event_payload[84:53], zero pad
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [kwm_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            req_tlast,    // last_of_list
   // rsp_tdata: out_key[31:0], out_payload[63:32], source_list[66:64], zero pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [kwm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [kwm_pkg::RSP_TUSER_W-1:0] rsp_tuser,    // status[2:0]
   input  logic                            csr_we,
   input  logic [kwm_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [kwm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import kwm_pkg::*;

   localparam int LIDX_W = $clog2(NUM_LISTS);
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int PTR_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CMP_W  = $clog2(NUM_LISTS + 1);
   localparam int ADDR_W = LIDX_W + PTR_W;
   localparam int DATA_W = KEY_WIDTH + PAYLOAD_WIDTH;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

   // configuration
   logic [3:0]  expected_ff;
   logic [15:0] cur_req_ff;

   // input register
   item_type item_ff;
   logic     item_vld_ff, item_vld_in;

   // list state
   logic [CNT_W-1:0]         fill_ff [NUM_LISTS];
   logic [CNT_W-1:0]         fill_in [NUM_LISTS];
   logic [CNT_W-1:0]         rp_ff   [NUM_LISTS];
   logic [CNT_W-1:0]         rp_in   [NUM_LISTS];
   logic [NUM_LISTS-1:0]     done_ff, done_in;
   logic [CMP_W-1:0]         ccount_ff, ccount_in;
   logic [KEY_WIDTH-1:0]     head_key_ff [NUM_LISTS];
   logic [KEY_WIDTH-1:0]     head_key_in [NUM_LISTS];
   logic [PAYLOAD_WIDTH-1:0] head_pay_ff [NUM_LISTS];
   logic [PAYLOAD_WIDTH-1:0] head_pay_in [NUM_LISTS];
   logic [NUM_LISTS-1:0]     head_vld;

   // head refetch
   logic              fetch_pend_ff, fetch_pend_in;
   logic [LIDX_W-1:0] fetch_list_ff, fetch_list_in;

   // result register
   logic        rsp_vld_ff, rsp_vld_in;
   status_type  status_ff, status_in;
   logic [31:0] okey_ff, okey_in;
   logic [31:0] opay_ff, opay_in;
   logic [2:0]  osrc_ff, osrc_in;

   // store ports
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;

   logic              found;
   logic [LIDX_W-1:0] best_idx;
   logic              advance;
   logic [LIDX_W-1:0] li_idx;
   logic              li_ok;
   logic [31:0]       eff_exp;
   logic [CNT_W-1:0]  rp_next;

   kwm_store #(
      .DATA_W (DATA_W),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   for (genvar g = 0; g < NUM_LISTS; g++) begin : g_vld
      assign head_vld[g] = rp_ff[g] < fill_ff[g];
   end

   kwm_min_sel #(
      .NUM_LISTS (NUM_LISTS),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_min_sel (
      .head_key (head_key_ff),
      .head_vld (head_vld),
      .found    (found),
      .best_idx (best_idx)
   );

   // handshake: item advances once the result slot frees and no refetch is due
   assign advance     = item_vld_ff && !fetch_pend_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready  = !item_vld_ff || advance;
   assign item_vld_in = (req_tvalid && req_tready) || (item_vld_ff && !advance);

   assign li_idx  = LIDX_W'(item_ff.list_index);
   assign li_ok   = 32'(item_ff.list_index) < 32'(NUM_LISTS);
   assign rp_next = rp_ff[best_idx] + CNT_W'(1);

   // zero acts as one, above the list count acts as the list count
   always_comb begin
      if (expected_ff == 4'd0) begin
         eff_exp = 32'd1;
      end else if (32'(expected_ff) > 32'(NUM_LISTS)) begin
         eff_exp = 32'(NUM_LISTS);
      end else begin
         eff_exp = 32'(expected_ff);
      end
   end

   always_comb begin
      fill_in       = fill_ff;
      rp_in         = rp_ff;
      done_in       = done_ff;
      ccount_in     = ccount_ff;
      head_key_in   = head_key_ff;
      head_pay_in   = head_pay_ff;
      fetch_pend_in = 1'b0;
      fetch_list_in = fetch_list_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      rsp_vld_in    = rsp_vld_ff && !rsp_tready;
      status_in     = status_ff;
      okey_in       = okey_ff;
      opay_in       = opay_ff;
      osrc_in       = osrc_ff;

      // refetched head arrives from the store read register in the cycle after the pop
      if (fetch_pend_ff) begin
         head_key_in[fetch_list_ff] = rd_data[KEY_WIDTH-1:0];
         head_pay_in[fetch_list_ff] = rd_data[DATA_W-1:KEY_WIDTH];
      end

      if (advance) begin
         rsp_vld_in = 1'b1;
         status_in  = ST_OK;
         okey_in    = '0;
         opay_in    = '0;
         osrc_in    = '0;
         case (cmd_type'(item_ff.command))
            CMD_PUSH: begin
               if (item_ff.request_id != cur_req_ff) begin
                  status_in = ST_STALE;
               end else if (!li_ok || done_ff[li_idx]) begin
                  status_in = ST_FULL;
               end else if (fill_ff[li_idx] >= DEPTH_CNT) begin
                  // dropped, but the end mark still closes the list
                  status_in = ST_FULL;
                  if (item_ff.last_of_list) begin
                     done_in[li_idx] = 1'b1;
                     ccount_in       = ccount_ff + CMP_W'(1);
                  end
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = {li_idx, fill_ff[li_idx][PTR_W-1:0]};
                  wr_data = {PAYLOAD_WIDTH'(item_ff.event_payload),
                             KEY_WIDTH'(item_ff.event_key)};
                  if (rp_ff[li_idx] == fill_ff[li_idx]) begin
                     head_key_in[li_idx] = KEY_WIDTH'(item_ff.event_key);
                     head_pay_in[li_idx] = PAYLOAD_WIDTH'(item_ff.event_payload);
                  end
                  fill_in[li_idx] = fill_ff[li_idx] + CNT_W'(1);
                  if (item_ff.last_of_list) begin
                     done_in[li_idx] = 1'b1;
                     ccount_in       = ccount_ff + CMP_W'(1);
                  end
               end
            end
            CMD_POP: begin
               if (32'(ccount_ff) < eff_exp) begin
                  status_in = ST_NOT_READY;
               end else if (found) begin
                  okey_in         = 32'(head_key_ff[best_idx]);
                  opay_in         = 32'(head_pay_ff[best_idx]);
                  osrc_in         = 3'(best_idx);
                  rp_in[best_idx] = rp_next;
                  if (rp_next < fill_ff[best_idx]) begin
                     rd_en         = 1'b1;
                     rd_addr       = {best_idx, rp_next[PTR_W-1:0]};
                     fetch_pend_in = 1'b1;
                     fetch_list_in = best_idx;
                  end
               end else begin
                  status_in = ST_FINISHED;
                  for (int i = 0; i < NUM_LISTS; i++) begin
                     fill_in[i] = '0;
                     rp_in[i]   = '0;
                  end
                  done_in   = '0;
                  ccount_in = '0;
               end
            end
            CMD_CLEAR: begin
               for (int i = 0; i < NUM_LISTS; i++) begin
                  fill_in[i] = '0;
                  rp_in[i]   = '0;
               end
               done_in   = '0;
               ccount_in = '0;
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff   <= 4'd1;
         cur_req_ff    <= '0;
         item_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         fetch_pend_ff <= 1'b0;
         done_ff       <= '0;
         ccount_ff     <= '0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            fill_ff[i] <= '0;
            rp_ff[i]   <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_EXPECTED_LISTS:  expected_ff <= csr_wdata[3:0];
               CSR_CURRENT_REQUEST: cur_req_ff  <= csr_wdata;
               default:             cur_req_ff  <= cur_req_ff;
            endcase
         end
         item_vld_ff   <= item_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
         fetch_pend_ff <= fetch_pend_in;
         done_ff       <= done_in;
         ccount_ff     <= ccount_in;
         fill_ff       <= fill_in;
         rp_ff         <= rp_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.command       <= req_tdata[1:0];
         item_ff.request_id    <= req_tdata[17:2];
         item_ff.list_index    <= req_tdata[20:18];
         item_ff.event_key     <= req_tdata[52:21];
         item_ff.event_payload <= req_tdata[84:53];
         item_ff.last_of_list  <= req_tlast;
      end
      head_key_ff   <= head_key_in;
      head_pay_ff   <= head_pay_in;
      fetch_list_ff <= fetch_list_in;
      status_ff     <= status_in;
      okey_ff       <= okey_in;
      opay_ff       <= opay_in;
      osrc_ff       <= osrc_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'd0, osrc_ff, opay_ff, okey_ff};
   assign rsp_tuser  = status_ff;

endmodule

>>> rtl/kwm_store.sv
// Event storage: one write port, one read port with registered read data.
// Depends on kwm_pkg (imported for house consistency).
module kwm_store #(
   parameter int DATA_W = 64,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   import kwm_pkg::*;

   logic [DATA_W-1:0] mem [1 << ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/kwm_min_sel.sv
// Arg-min tree over the cached list heads; ties go to the lower list.
// Depends on kwm_pkg.
module kwm_min_sel #(
   parameter  int NUM_LISTS = 8,
   parameter  int KEY_WIDTH = 32,
   localparam int LIDX_W    = $clog2(NUM_LISTS)
) (
   input  logic [KEY_WIDTH-1:0] head_key [NUM_LISTS],
   input  logic [NUM_LISTS-1:0] head_vld,
   output logic                 found,
   output logic [LIDX_W-1:0]    best_idx
);
   import kwm_pkg::*;

   localparam int NODES = 1 << LIDX_W;

   logic [KEY_WIDTH-1:0] nkey [2*NODES];
   logic [LIDX_W-1:0]    nidx [2*NODES];
   logic                 nvld [2*NODES];

   always_comb begin
      logic take_r;
      take_r  = 1'b0;
      nkey[0] = '0;
      nidx[0] = '0;
      nvld[0] = 1'b0;
      // leaves, padded up to a power of two
      for (int i = 0; i < NODES; i++) begin
         if (i < NUM_LISTS) begin
            nvld[NODES+i] = head_vld[i];
            nkey[NODES+i] = head_key[i];
         end else begin
            nvld[NODES+i] = 1'b0;
            nkey[NODES+i] = '0;
         end
         nidx[NODES+i] = LIDX_W'(i);
      end
      // internal nodes; right side wins only on a strictly smaller key
      for (int j = NODES - 1; j >= 1; j--) begin
         take_r = nvld[2*j+1] && (!nvld[2*j] || (nkey[2*j+1] < nkey[2*j]));
         nvld[j] = nvld[2*j] || nvld[2*j+1];
         nkey[j] = take_r ? nkey[2*j+1] : nkey[2*j];
         nidx[j] = take_r ? nidx[2*j+1] : nidx[2*j];
      end
   end

   assign found    = nvld[1];
   assign best_idx = nidx[1];

endmodule
